// ===== rtl/fragment_reassembler_core_defines.svh =====
// Assertion macros for the fragment reassembler core
`ifndef FRAGMENT_REASSEMBLER_CORE_DEFINES_SVH
`define FRAGMENT_REASSEMBLER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, quiet during reset
`define FRS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet during reset
`define FRS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/frs_pkg.sv =====
// Types and constants shared by the fragment reassembler modules
`default_nettype none
package frs_pkg;

   localparam int MSG_BYTES = 8192;
   localparam int ADDR_W    = 13;
   localparam int LEN_W     = 14;
   localparam int LC_W      = 32;
   localparam int SEQ_W     = 6;
   localparam int LEN_HDR   = 4;

   localparam logic [LEN_W-1:0] MSG_LEN   = LEN_W'(MSG_BYTES);
   localparam logic [LC_W-1:0]  MSG_LEN32 = LC_W'(MSG_BYTES);

   typedef enum logic [1:0] {
      KIND_SINGLE,
      KIND_START,
      KIND_CONT,
      KIND_END
   } frs_kind_type;

   typedef enum logic [3:0] {
      EV_READ,
      EV_IGNORED,
      EV_CONT_OK,
      EV_START_OK,
      EV_DELIVERED,
      EV_TOO_LARGE,
      EV_START_TOO_LARGE,
      EV_SEQ_MISMATCH,
      EV_OVERFLOW,
      EV_LEN_MISMATCH
   } frs_event_type;

   typedef struct packed {
      logic              func;
      logic [7:0]        data_byte;
      logic              packet_first;
      logic              packet_last;
      logic [ADDR_W-1:0] read_address;
   } frs_item_type;

   typedef struct packed {
      frs_event_type    event_res;
      logic [LEN_W-1:0] message_length;
      logic             read_hit;
   } frs_result_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } frs_store_req_type;

endpackage
`default_nettype wire

// ===== rtl/fragment_reassembler_core.sv =====
// Fragment reassembler top level: input register, packet control, store, result register
//
// Rebuilds messages from link packets fed one byte per transfer and answers
// byte reads of the last delivered message. One item is taken every clock
// unless the input stalls; each item is registered, judged by the packet
// control logic (one store write or one store read) in the cycle it leaves
// the input register, and any result is loaded into the result register at
// the end of that cycle, from which it is offered until taken.
// Items that give no result (packet bytes other than the last) flow
// through even while a result is held. The input stalls only while a held
// result is not taken and the registered item would produce another. The
// message store needs no clearing after reset; reads are limited to the
// delivered length, so unwritten bytes are never returned.
`default_nettype none
`include "fragment_reassembler_core_defines.svh"
module fragment_reassembler_core #(
   parameter int PACKET_BYTES = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_func,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_packet_first,
   input  wire logic        req_packet_last,
   input  wire logic [12:0] req_read_address,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_event_res,
   output logic [13:0]      rsp_message_length,
   output logic [7:0]       rsp_read_data
);

   logic                        s1_valid_ff, s1_valid_in;
   frs_pkg::frs_item_type       s1_item_ff;
   logic                        s1_needs_out;
   logic                        s1_fire;
   logic                        out_free;
   logic                        req_take;

   logic                        rsp_valid_ff, rsp_valid_in;
   frs_pkg::frs_result_type     rsp_result_ff;

   frs_pkg::frs_result_type     result;
   frs_pkg::frs_store_req_type  store_req;
   logic [7:0]                  store_rd_data;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign s1_needs_out = s1_item_ff.func || s1_item_ff.packet_last;
   assign s1_fire      = s1_valid_ff && (!s1_needs_out || out_free);
   assign req_stall    = s1_valid_ff && !s1_fire;
   assign req_take     = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && s1_needs_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // capture each input transfer
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.func         <= req_func;
         s1_item_ff.data_byte    <= req_data_byte;
         s1_item_ff.packet_first <= req_packet_first;
         s1_item_ff.packet_last  <= req_packet_last;
         s1_item_ff.read_address <= req_read_address;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_needs_out) begin
         rsp_result_ff <= result;
      end
   end

   frs_packet_ctrl #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .fire      (s1_fire),
      .item      (s1_item_ff),
      .result    (result),
      .store_req (store_req)
   );

   frs_msg_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data   (store_rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_res      = rsp_result_ff.event_res;
   assign rsp_message_length = rsp_result_ff.message_length;
   assign rsp_read_data      = rsp_result_ff.read_hit ? store_rd_data : 8'd0;

   `FRS_ASSERT_IMP(a_event_no_data,
      rsp_valid && (rsp_event_res != frs_pkg::EV_READ), rsp_read_data == 8'd0,
      "packet event carries read data")
   `FRS_ASSERT_NXT(a_item_held,
      s1_valid_ff && !s1_fire, s1_valid_ff && $stable(s1_item_ff),
      "stalled item lost")
   `FRS_ASSERT_IMP(a_stall_cause,
      req_stall, rsp_valid && rsp_stall,
      "input stalled without held result")

endmodule
`default_nettype wire

// ===== rtl/frs_msg_store.sv =====
// Message byte store: one write port, one registered read port
`default_nettype none
module frs_msg_store (
   input  wire logic                        clock,
   input  wire frs_pkg::frs_store_req_type  store_req,
   output logic [7:0]                       rd_data
);

   logic [7:0] mem [frs_pkg::MSG_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
   end

   // hold read data unless a new read is issued
   always_ff @(posedge clock) begin
      if (store_req.rd_en) begin
         rd_data_ff <= mem[store_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/frs_packet_ctrl.sv =====
// Packet tracking, message state and event decision for one registered item
`default_nettype none
module frs_packet_ctrl #(
   parameter int PACKET_BYTES = 512
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        fire,
   input  wire frs_pkg::frs_item_type       item,
   output frs_pkg::frs_result_type          result,
   output frs_pkg::frs_store_req_type       store_req
);

   localparam int CNT_W = $clog2(PACKET_BYTES + 2);
   localparam int SUM_W = ((frs_pkg::LEN_W > CNT_W) ? frs_pkg::LEN_W : CNT_W) + 1;
   localparam logic [CNT_W-1:0] PKT_MAX = CNT_W'(PACKET_BYTES);
   localparam logic [CNT_W-1:0] PKT_SAT = CNT_W'(PACKET_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_HDR = CNT_W'(frs_pkg::LEN_HDR);

   frs_pkg::frs_kind_type          type_ff, type_in;
   logic [frs_pkg::SEQ_W-1:0]      seq_ff, seq_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [frs_pkg::LC_W-1:0]       lc_ff, lc_in;
   logic                           inprog_ff, inprog_in;
   logic [frs_pkg::LEN_W-1:0]      total_ff, total_in;
   logic [frs_pkg::LEN_W-1:0]      rcvd_ff, rcvd_in;
   logic [frs_pkg::SEQ_W-1:0]      expseq_ff, expseq_in;
   logic [frs_pkg::LEN_W-1:0]      dlvd_ff, dlvd_in;

   logic [CNT_W-1:0]               idx;
   logic [CNT_W-1:0]               start_pos;
   logic [SUM_W-1:0]               cont_pos;
   logic [CNT_W-1:0]               plen;
   logic [CNT_W-1:0]               rest;
   logic [SUM_W-1:0]               rsum;
   logic                           wr_hit;
   logic [frs_pkg::ADDR_W-1:0]     wr_pos;
   frs_pkg::frs_event_type         ev;

   always_comb begin
      type_in   = type_ff;
      seq_in    = seq_ff;
      count_in  = count_ff;
      lc_in     = lc_ff;
      inprog_in = inprog_ff;
      total_in  = total_ff;
      rcvd_in   = rcvd_ff;
      expseq_in = expseq_ff;
      dlvd_in   = dlvd_ff;
      idx       = count_ff - CNT_ONE;
      start_pos = idx - CNT_HDR;
      cont_pos  = SUM_W'(rcvd_ff) + SUM_W'(idx);
      plen      = '0;
      rest      = '0;
      rsum      = '0;
      wr_hit    = 1'b0;
      wr_pos    = '0;
      ev        = frs_pkg::EV_IGNORED;
      result    = '0;
      store_req = '0;

      if (item.func) begin
         // read one byte of the delivered message
         store_req.rd_en       = fire;
         store_req.rd_addr     = item.read_address;
         result.event_res      = frs_pkg::EV_READ;
         result.message_length = dlvd_ff;
         result.read_hit       = (frs_pkg::LEN_W'(item.read_address) < dlvd_ff);
      end else begin
         if (item.packet_first) begin
            type_in  = frs_pkg::frs_kind_type'(item.data_byte[7:6]);
            seq_in   = item.data_byte[5:0];
            count_in = CNT_ONE;
            lc_in    = '0;
         end else if (count_ff != '0) begin
            if (count_ff < PKT_MAX) begin
               unique case (type_ff)
                  frs_pkg::KIND_SINGLE: begin
                     wr_hit = (SUM_W'(idx) < SUM_W'(frs_pkg::MSG_LEN));
                     wr_pos = frs_pkg::ADDR_W'(idx);
                  end
                  frs_pkg::KIND_START: begin
                     if (idx < CNT_HDR) begin
                        lc_in = {lc_ff[frs_pkg::LC_W-9:0], item.data_byte};
                     end else begin
                        wr_hit = (lc_ff <= frs_pkg::MSG_LEN32) &&
                                 (frs_pkg::LC_W'(start_pos) < lc_ff);
                        wr_pos = frs_pkg::ADDR_W'(start_pos);
                     end
                  end
                  frs_pkg::KIND_CONT, frs_pkg::KIND_END: begin
                     wr_hit = inprog_ff && (total_ff != '0) && (seq_ff == expseq_ff) &&
                              (cont_pos < SUM_W'(total_ff)) &&
                              (cont_pos < SUM_W'(frs_pkg::MSG_LEN));
                     wr_pos = cont_pos[frs_pkg::ADDR_W-1:0];
                  end
                  default: ;
               endcase
            end
            // saturate one past the packet limit
            if (count_ff < PKT_SAT) begin
               count_in = count_ff + CNT_ONE;
            end
         end

         store_req.wr_en   = fire && wr_hit;
         store_req.wr_addr = wr_pos;
         store_req.wr_data = item.data_byte;

         if (item.packet_last) begin
            if (count_in == '0) begin
               ev = frs_pkg::EV_IGNORED;
            end else begin
               plen     = count_in - CNT_ONE;
               rest     = plen - CNT_HDR;
               rsum     = SUM_W'(rcvd_ff) + SUM_W'(plen);
               count_in = '0;
               if (plen >= PKT_MAX) begin
                  ev = frs_pkg::EV_TOO_LARGE;
               end else begin
                  unique case (type_in)
                     frs_pkg::KIND_SINGLE: begin
                        if (SUM_W'(plen) >= SUM_W'(frs_pkg::MSG_LEN)) begin
                           ev = frs_pkg::EV_TOO_LARGE;
                        end else begin
                           dlvd_in   = frs_pkg::LEN_W'(plen);
                           total_in  = '0;
                           rcvd_in   = '0;
                           inprog_in = 1'b0;
                           ev        = frs_pkg::EV_DELIVERED;
                        end
                     end
                     frs_pkg::KIND_START: begin
                        if (plen < CNT_HDR) begin
                           ev = frs_pkg::EV_IGNORED;
                        end else if (lc_in > frs_pkg::MSG_LEN32) begin
                           total_in = '0;
                           ev       = frs_pkg::EV_TOO_LARGE;
                        end else begin
                           inprog_in = 1'b1;
                           expseq_in = seq_in + frs_pkg::SEQ_W'(1);
                           if (frs_pkg::LC_W'(rest) > lc_in) begin
                              total_in  = '0;
                              rcvd_in   = '0;
                              inprog_in = 1'b0;
                              ev        = frs_pkg::EV_START_TOO_LARGE;
                           end else begin
                              total_in = lc_in[frs_pkg::LEN_W-1:0];
                              rcvd_in  = frs_pkg::LEN_W'(rest);
                              ev       = frs_pkg::EV_START_OK;
                           end
                        end
                     end
                     frs_pkg::KIND_CONT, frs_pkg::KIND_END: begin
                        if ((total_ff == '0) || !inprog_ff) begin
                           ev = frs_pkg::EV_IGNORED;
                        end else if (seq_in != expseq_ff) begin
                           total_in  = '0;
                           rcvd_in   = '0;
                           inprog_in = 1'b0;
                           ev        = frs_pkg::EV_SEQ_MISMATCH;
                        end else begin
                           if (type_in == frs_pkg::KIND_CONT) begin
                              expseq_in = expseq_ff + frs_pkg::SEQ_W'(1);
                           end
                           if (rsum > SUM_W'(total_ff)) begin
                              total_in  = '0;
                              rcvd_in   = '0;
                              inprog_in = 1'b0;
                              ev        = frs_pkg::EV_OVERFLOW;
                           end else if (type_in == frs_pkg::KIND_CONT) begin
                              rcvd_in = rsum[frs_pkg::LEN_W-1:0];
                              ev      = frs_pkg::EV_CONT_OK;
                           end else begin
                              total_in  = '0;
                              rcvd_in   = '0;
                              inprog_in = 1'b0;
                              if (rsum == SUM_W'(total_ff)) begin
                                 dlvd_in = total_ff;
                                 ev      = frs_pkg::EV_DELIVERED;
                              end else begin
                                 ev = frs_pkg::EV_LEN_MISMATCH;
                              end
                           end
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end

         result.event_res      = ev;
         result.message_length = (ev == frs_pkg::EV_DELIVERED) ? dlvd_in : rcvd_in;
         result.read_hit       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff   <= frs_pkg::KIND_SINGLE;
         seq_ff    <= '0;
         count_ff  <= '0;
         lc_ff     <= '0;
         inprog_ff <= 1'b0;
         total_ff  <= '0;
         rcvd_ff   <= '0;
         expseq_ff <= '0;
         dlvd_ff   <= '0;
      end else if (fire) begin
         type_ff   <= type_in;
         seq_ff    <= seq_in;
         count_ff  <= count_in;
         lc_ff     <= lc_in;
         inprog_ff <= inprog_in;
         total_ff  <= total_in;
         rcvd_ff   <= rcvd_in;
         expseq_ff <= expseq_in;
         dlvd_ff   <= dlvd_in;
      end
   end

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the fragment reassembler core
`timescale 1ns / 1ps
module testbench;

   localparam int PKT_BYTES = 512;

   typedef struct {
      frs_pkg::frs_event_type    ev_code;
      logic [frs_pkg::LEN_W-1:0] msg_len;
      logic [7:0]                data;
   } event_rec_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_type;
   typedef enum {FAULT_NONE, FAULT_SEQ, FAULT_OVERFLOW, FAULT_SHORT, FAULT_ABANDON} fault_type;
   typedef enum {
      NOISE_STRAY,
      NOISE_RANDOM_HDR,
      NOISE_BIG_LEN,
      NOISE_FULL_LEN,
      NOISE_OVERSIZE,
      NOISE_TINY_LEN
   } noise_type;

   // Mirrors the reassembly state and queues the events each transfer should give
   class frag_scoreboard;
      frs_pkg::frs_kind_type pkt_kind = frs_pkg::KIND_SINGLE;
      bit [5:0]      pkt_seq;
      int unsigned   pkt_bytes;
      bit [31:0]     len_word;
      bit            msg_open;
      int unsigned   msg_total;
      int unsigned   recv_len;
      bit [5:0]      next_seq;
      int unsigned   deliv_len;
      bit [7:0]      msg_mem [frs_pkg::MSG_BYTES];
      event_rec_type pending_events[$];
      int unsigned   faults;

      function void abandon_message();
         msg_total = 0;
         recv_len  = 0;
         msg_open  = 1'b0;
      endfunction

      function void note_item(frs_pkg::frs_item_type it);
         int unsigned idx, p, plen, rest;
         bit [7:0] b;
         frs_pkg::frs_event_type ev;
         b = it.data_byte;
         if (it.func) begin
            b = 8'h00;
            if (it.read_address < deliv_len) b = msg_mem[it.read_address];
            pending_events.push_back('{frs_pkg::EV_READ, 14'(deliv_len), b});
            return;
         end
         if (it.packet_first) begin
            pkt_kind  = frs_pkg::frs_kind_type'(b[7:6]);
            pkt_seq   = b[5:0];
            pkt_bytes = 1;
            len_word  = '0;
         end else if (pkt_bytes != 0) begin
            // bytes land in the store as they arrive, whatever the verdict later
            if (pkt_bytes < PKT_BYTES) begin
               idx = pkt_bytes - 1;
               if (pkt_kind == frs_pkg::KIND_SINGLE) begin
                  if (idx < frs_pkg::MSG_BYTES) msg_mem[idx] = b;
               end else if (pkt_kind == frs_pkg::KIND_START) begin
                  if (idx < frs_pkg::LEN_HDR)
                     len_word = {len_word[23:0], b};
                  else if (len_word <= frs_pkg::MSG_LEN32 && idx - frs_pkg::LEN_HDR < len_word)
                     msg_mem[idx - frs_pkg::LEN_HDR] = b;
               end else begin
                  p = recv_len + idx;
                  if (msg_open && msg_total != 0 && pkt_seq == next_seq &&
                      p < msg_total && p < frs_pkg::MSG_BYTES)
                     msg_mem[p] = b;
               end
            end
            if (pkt_bytes <= PKT_BYTES) pkt_bytes++;
         end
         if (!it.packet_last) return;

         if (pkt_bytes == 0) begin
            ev = frs_pkg::EV_IGNORED;
         end else begin
            plen = pkt_bytes - 1;
            if (pkt_bytes > PKT_BYTES) begin
               ev = frs_pkg::EV_TOO_LARGE;
            end else if (pkt_kind == frs_pkg::KIND_SINGLE) begin
               if (plen >= frs_pkg::MSG_BYTES) begin
                  ev = frs_pkg::EV_TOO_LARGE;
               end else begin
                  deliv_len = plen;
                  abandon_message();
                  ev = frs_pkg::EV_DELIVERED;
               end
            end else if (pkt_kind == frs_pkg::KIND_START) begin
               if (plen < frs_pkg::LEN_HDR) begin
                  ev = frs_pkg::EV_IGNORED;
               end else if (len_word > frs_pkg::MSG_LEN32) begin
                  msg_total = 0;
                  ev = frs_pkg::EV_TOO_LARGE;
               end else begin
                  next_seq = pkt_seq + 6'd1;
                  rest = plen - frs_pkg::LEN_HDR;
                  if (rest > len_word) begin
                     abandon_message();
                     ev = frs_pkg::EV_START_TOO_LARGE;
                  end else begin
                     msg_total = len_word;
                     recv_len  = rest;
                     msg_open  = 1'b1;
                     ev = frs_pkg::EV_START_OK;
                  end
               end
            end else if (msg_total == 0 || !msg_open) begin
               ev = frs_pkg::EV_IGNORED;
            end else if (pkt_seq != next_seq) begin
               abandon_message();
               ev = frs_pkg::EV_SEQ_MISMATCH;
            end else begin
               if (pkt_kind == frs_pkg::KIND_CONT) next_seq = next_seq + 6'd1;
               if (recv_len + plen > msg_total) begin
                  abandon_message();
                  ev = frs_pkg::EV_OVERFLOW;
               end else begin
                  recv_len += plen;
                  if (pkt_kind == frs_pkg::KIND_CONT) begin
                     ev = frs_pkg::EV_CONT_OK;
                  end else begin
                     if (recv_len == msg_total) begin
                        deliv_len = recv_len;
                        ev = frs_pkg::EV_DELIVERED;
                     end else begin
                        ev = frs_pkg::EV_LEN_MISMATCH;
                     end
                     abandon_message();
                  end
               end
            end
            pkt_bytes = 0;
         end
         pending_events.push_back('{ev,
                                    (ev == frs_pkg::EV_DELIVERED) ? 14'(deliv_len)
                                                                  : 14'(recv_len),
                                    8'h00});
      endfunction

      function void check_event(logic [3:0] ev, logic [frs_pkg::LEN_W-1:0] len,
                                logic [7:0] data);
         event_rec_type want;
         if (pending_events.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected result: event %0d length %0d data %0d", ev, len, data);
            return;
         end
         want = pending_events.pop_front();
         if (ev !== want.ev_code || len !== want.msg_len || data !== want.data) begin
            faults++;
            if (faults <= 10)
               $display("mismatch: event %0d/%0d length %0d/%0d data %0d/%0d (want/got)",
                        want.ev_code, ev, want.msg_len, len, want.data, data);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_packet_first = 1'b0;
   logic        req_packet_last = 1'b0;
   logic [12:0] req_read_address = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_event_res;
   logic [13:0] rsp_message_length;
   logic [7:0]  rsp_read_data;

   frag_scoreboard sb;
   bit [7:0]       body[$];
   int unsigned    burst_left;
   int unsigned    items_sent;
   stall_mode_type stall_mode;
   int unsigned    mode_left, run_left;
   bit             run_state;

   fragment_reassembler_core #(.PACKET_BYTES(PKT_BYTES)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_data_byte(req_data_byte),
      .req_packet_first(req_packet_first),
      .req_packet_last(req_packet_last),
      .req_read_address(req_read_address),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_event_res(rsp_event_res),
      .rsp_message_length(rsp_message_length),
      .rsp_read_data(rsp_read_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_item('{func: req_func, data_byte: req_data_byte,
                           packet_first: req_packet_first, packet_last: req_packet_last,
                           read_address: req_read_address});
         if (rsp_valid && !rsp_stall)
            sb.check_event(rsp_event_res, rsp_message_length, rsp_read_data);
      end
   end

   // Receiver back-pressure: switch between stall patterns every so often
   always @(negedge clock) begin
      if (mode_left == 0) begin
         mode_left  = $urandom_range(32, 200);
         stall_mode = stall_mode_type'($urandom_range(0, 3));
      end
      mode_left--;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= 1'($urandom_range(0, 1));
         default: begin
            if (run_left == 0) begin
               run_state = !run_state;
               run_left  = $urandom_range(1, 8);
            end
            run_left--;
            rsp_stall <= run_state;
         end
      endcase
   end

   // Present one transfer at a falling edge and hold it until taken
   task send_item(input bit func, input bit [7:0] data, input bit first, input bit last,
                  input bit [12:0] addr);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid        <= 1'b0;
            req_func         <= 1'($urandom);
            req_data_byte    <= 8'($urandom);
            req_packet_first <= 1'($urandom);
            req_packet_last  <= 1'($urandom);
            req_read_address <= 13'($urandom);
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_func         <= func;
      req_data_byte    <= data;
      req_packet_first <= first;
      req_packet_last  <= last;
      req_read_address <= addr;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   function void add_random(int unsigned n);
      for (int i = 0; i < n; i++) body.push_back(8'($urandom));
   endfunction

   function void add_length(bit [31:0] v);
      for (int i = 3; i >= 0; i--) body.push_back(v[8*i +: 8]);
   endfunction

   // Send header plus the queued body; last flag goes on the final byte
   task send_packet(input frs_pkg::frs_kind_type kind, input bit [5:0] seq);
      send_item(1'b0, {kind, seq}, 1'b1, body.size() == 0, 13'($urandom));
      foreach (body[i])
         send_item(1'b0, body[i], 1'b0, i == body.size() - 1, 13'($urandom));
      body.delete();
   endtask

   task read_some(input int unsigned n);
      int unsigned addr;
      for (int i = 0; i < n; i++) begin
         addr = (sb.deliv_len != 0 && $urandom_range(0, 3) != 0) ?
                $urandom_range(0, sb.deliv_len + 2) : $urandom;
         send_item(1'b1, 8'($urandom), 1'($urandom), 1'($urandom), 13'(addr));
      end
   endtask

   task send_message();
      int unsigned total, rest, left, part;
      bit [5:0] seq;
      fault_type fault;
      total = ($urandom_range(0, 9) == 0) ? $urandom_range(300, 700) : $urandom_range(0, 120);
      fault = ($urandom_range(0, 2) == 0) ? fault_type'($urandom_range(1, 4)) : FAULT_NONE;
      seq   = 6'($urandom);
      rest  = $urandom_range(0, (total < 60) ? total : 60);
      add_length(total);
      add_random(rest);
      send_packet(frs_pkg::KIND_START, seq);
      left = total - rest;
      while (left != 0) begin
         part = $urandom_range(1, (left < 90) ? left : 90);
         if (part == left && $urandom_range(0, 1)) break;
         seq++;
         add_random(part);
         send_packet(frs_pkg::KIND_CONT, seq);
         left -= part;
      end
      if (fault == FAULT_ABANDON) begin
         // open a continue packet and drop it under a fresh header
         send_item(1'b0, {frs_pkg::KIND_CONT, seq + 6'd1}, 1'b1, 1'b0, 13'($urandom));
         repeat ($urandom_range(1, 4))
            send_item(1'b0, 8'($urandom), 1'b0, 1'b0, 13'($urandom));
      end
      seq++;
      if (fault == FAULT_SEQ) seq += 6'($urandom_range(1, 63));
      if (fault == FAULT_OVERFLOW) left += $urandom_range(1, 5);
      if (fault == FAULT_SHORT && left != 0) left -= $urandom_range(1, left);
      add_random(left);
      send_packet(frs_pkg::KIND_END, seq);
      read_some($urandom_range(1, 4));
   endtask

   task send_noise(input noise_type kind);
      int unsigned n;
      bit [5:0] seq;
      seq = 6'($urandom);
      case (kind)
         NOISE_STRAY: begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
               send_item(1'b0, 8'($urandom), 1'b0, (i == n - 1) && $urandom_range(0, 1),
                         13'($urandom));
         end
         NOISE_RANDOM_HDR: begin
            add_random($urandom_range(0, 6));
            send_packet(frs_pkg::frs_kind_type'($urandom_range(0, 3)), seq);
         end
         NOISE_BIG_LEN: begin
            add_length($urandom);
            add_random($urandom_range(0, 3));
            send_packet(frs_pkg::KIND_START, seq);
         end
         NOISE_FULL_LEN: begin
            add_length(frs_pkg::MSG_LEN32);
            add_random($urandom_range(0, 3));
            send_packet(frs_pkg::KIND_START, seq);
            add_random($urandom_range(0, 3));
            send_packet(frs_pkg::KIND_END, seq + 6'd1);
         end
         NOISE_OVERSIZE: begin
            add_random($urandom_range(PKT_BYTES, PKT_BYTES + 20));
            send_packet(frs_pkg::frs_kind_type'($urandom_range(0, 3)), seq);
            read_some(2);
         end
         default: begin
            // tiny declared length: payload may exceed it, or a zero-length message opens
            add_length($urandom_range(0, 3));
            add_random($urandom_range(0, 6));
            send_packet(frs_pkg::KIND_START, seq);
            add_random($urandom_range(0, 2));
            send_packet(frs_pkg::frs_kind_type'($urandom_range(2, 3)), seq + 6'd1);
         end
      endcase
   endtask

   initial begin
      int unsigned stop_at, pick, round;
      noise_type noise;
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reads before any delivery, stray bytes, orphans, start and single-packet corner cases
      send_item(1'b1, 8'h00, 1'b0, 1'b0, 13'd0);
      send_item(1'b1, 8'hFF, 1'b1, 1'b1, 13'h1FFF);
      send_item(1'b0, 8'hFF, 1'b0, 1'b0, 13'd0);
      send_item(1'b0, 8'h00, 1'b0, 1'b1, 13'h1FFF);
      send_packet(frs_pkg::KIND_SINGLE, 6'h3F);
      send_packet(frs_pkg::KIND_CONT, 6'h00);
      send_packet(frs_pkg::KIND_END, 6'h3F);
      add_random(1);
      send_packet(frs_pkg::KIND_START, 6'h00);
      add_length(frs_pkg::MSG_LEN32 + 32'd1);
      send_packet(frs_pkg::KIND_START, 6'h01);
      add_length(32'd1);
      add_random(2);
      send_packet(frs_pkg::KIND_START, 6'h02);
      add_random(2);
      send_packet(frs_pkg::KIND_SINGLE, 6'h05);
      send_item(1'b1, 8'h00, 1'b0, 1'b0, 13'd1);
      send_item(1'b1, 8'h00, 1'b0, 1'b0, 13'd2);

      stop_at = items_sent + 900;
      round = 0;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (round == 2) begin
            send_noise(NOISE_OVERSIZE);
         end else if (pick < 45) begin
            send_message();
         end else if (pick < 60) begin
            add_random(($urandom_range(0, 19) == 0) ? PKT_BYTES - 1 : $urandom_range(0, 100));
            send_packet(frs_pkg::KIND_SINGLE, 6'($urandom));
            read_some($urandom_range(0, 3));
         end else if (pick < 80) begin
            read_some($urandom_range(2, 6));
         end else begin
            noise = noise_type'($urandom_range(0, 5));
            if (noise == NOISE_OVERSIZE && $urandom_range(0, 2) != 0) noise = NOISE_RANDOM_HDR;
            send_noise(noise);
         end
         round++;
      end
      req_valid <= 1'b0;

      for (int i = 0; i < 20000 && sb.pending_events.size() != 0; i++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.pending_events.size() != 0) begin
         sb.faults++;
         if (sb.faults <= 10)
            $display("%0d expected results never arrived", sb.pending_events.size());
      end
      if (sb.faults == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
